/* rtl/dwq_pkg.sv */
// Shared types and codes for the deduplicating work queue dispatch unit.
// No dependencies.
package dwq_pkg;

   localparam int MODE_W   = 2;
   localparam int WORKER_W = 3;
   localparam int WCNT_W   = 4;
   localparam int STATUS_W = 3;

   localparam logic [WCNT_W-1:0] WCNT_RESET = 4'd8;

   localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DONE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUP   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NULL  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BADW  = 3'd5;

   // queue chain control, common to every cell
   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   // per worker slot control
   typedef struct packed {
      logic load;
      logic clear;
   } slot_ctrl_type;

endpackage

/* rtl/dwq_queue_cell.sv */
// One entry of the shifting work queue: shifts towards the head on pop,
// loads at the tail on push, and compares its handle with the probe.
// Depends on dwq_pkg.
module dwq_queue_cell #(
   parameter int ID_W  = 16,
   parameter int CNT_W = 5,
   parameter int IDX   = 0
) (
   input  logic                clock,
   input  dwq_pkg::q_ctrl_type ctrl,
   input  logic [CNT_W-1:0]    fill,
   input  logic [ID_W-1:0]     probe_id,
   input  logic [ID_W-1:0]     next_val,
   output logic [ID_W-1:0]     val,
   output logic                hit
);
   import dwq_pkg::*;

   logic [ID_W-1:0] val_ff;
   logic            occupied;

   assign occupied = CNT_W'(IDX) < fill;

   always_ff @(posedge clock) begin
      if (ctrl.pop) begin
         val_ff <= next_val;
      end else if (ctrl.push && (fill == CNT_W'(IDX))) begin
         val_ff <= probe_id;
      end
   end

   assign val = val_ff;
   assign hit = occupied && (val_ff == probe_id);

endmodule

/* rtl/dwq_slot_cell.sv */
// One worker slot: holds the handle a worker is busy with, 0 when idle.
// Reports a match against the probe only while the slot is active.
// Depends on dwq_pkg.
module dwq_slot_cell #(
   parameter int ID_W = 16,
   parameter int IDX  = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dwq_pkg::slot_ctrl_type     ctrl,
   input  logic [dwq_pkg::WCNT_W-1:0] active_cnt,
   input  logic [ID_W-1:0]            load_val,
   input  logic [ID_W-1:0]            probe_id,
   output logic [ID_W-1:0]            val,
   output logic                       hit
);
   import dwq_pkg::*;

   logic [ID_W-1:0] val_ff;
   logic            active;

   assign active = 7'(IDX) < {3'b000, active_cnt};

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else if (ctrl.load) begin
         val_ff <= load_val;
      end else if (ctrl.clear) begin
         val_ff <= '0;
      end
   end

   assign val = val_ff;
   assign hit = active && (val_ff == probe_id);

endmodule

/* rtl/dedup_work_queue_dispatch_unit.sv */
// Top level of the deduplicating work queue dispatch unit.
// Depends on dwq_pkg, dwq_queue_cell and dwq_slot_cell.
//
// Usage:
//  req channel: one request per beat. req_tuser carries the mode (push, pop
//  to worker, worker done); req_tdata carries the item handle and the worker.
//  rsp channel: exactly one response beat per request. rsp_tuser carries the
//  status code; rsp_tdata carries the handle handed out and the occupancy.
//  csr_wr_en/csr_wr_data write the active worker count; write only when idle.
//  The queue is a row of cells that shift one place towards the head on each
//  pop; the duplicate check compares the handle against every queued cell
//  and every active slot at once, so a request resolves in the cycle it is
//  accepted and its response appears on the following cycle.
//  Throughput is one request per cycle, set by the single response register:
//  req_tready is high while that register is empty or being drained.
//  When the receiver stalls, the response holds and new requests wait.
//  Reset empties the queue, clears all worker slots and sets the worker count
//  to 8, with no clearing pass.
module dedup_work_queue_dispatch_unit #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_WORKERS = 8,
   parameter int ID_WIDTH    = 16,
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
   localparam int REQ_DATA_W = ((ID_WIDTH + dwq_pkg::WORKER_W + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((ID_WIDTH + CNT_W + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [dwq_pkg::WCNT_W-1:0]   csr_wr_data,  // worker_count
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [REQ_DATA_W-1:0]        req_tdata,    // item_id, worker, zero pad
   input  logic [dwq_pkg::MODE_W-1:0]   req_tuser,    // mode
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_DATA_W-1:0]        rsp_tdata,    // item_out, occupancy, zero pad
   output logic [dwq_pkg::STATUS_W-1:0] rsp_tuser     // status
);
   import dwq_pkg::*;

   logic [WCNT_W-1:0]   wcnt_ff, active_cnt;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff, status_in;
   logic [ID_WIDTH-1:0] rsp_item_ff, given;
   logic [CNT_W-1:0]    rsp_occ_ff;

   logic [MODE_W-1:0]   mode;
   logic [ID_WIDTH-1:0] id;
   logic [WORKER_W-1:0] w;
   logic                req_fire;
   logic                dup, full, empty, badw, busy;
   logic                push_ok, pop_ok, done_ok;

   logic [ID_WIDTH-1:0] q_val  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] q_hit;
   logic [ID_WIDTH-1:0] s_val  [MAX_WORKERS];
   logic [MAX_WORKERS-1:0] s_hit;
   q_ctrl_type          q_ctrl;
   slot_ctrl_type       s_ctrl [MAX_WORKERS];

   assign mode     = req_tuser;
   assign id       = req_tdata[ID_WIDTH-1:0];
   assign w        = req_tdata[ID_WIDTH +: WORKER_W];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire = req_tvalid && req_tready;

   // counts above the slot count behave as the slot count
   always_comb begin
      if ({3'b000, wcnt_ff} > 7'(MAX_WORKERS)) begin
         active_cnt = WCNT_W'(MAX_WORKERS);
      end else begin
         active_cnt = wcnt_ff;
      end
   end

   assign dup   = (|q_hit) || (|s_hit);
   assign full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign badw  = ({4'b0000, w} >= {3'b000, active_cnt}) || ({4'b0000, w} >= 7'(MAX_WORKERS));

   always_comb begin
      busy = 1'b0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
         if (({4'b0000, w} == 7'(i)) && (s_val[i] != '0)) begin
            busy = 1'b1;
         end
      end
   end

   always_comb begin
      status_in = ST_OK;
      push_ok   = 1'b0;
      pop_ok    = 1'b0;
      done_ok   = 1'b0;
      unique case (mode)
         MODE_PUSH: begin
            if (id == '0) begin
               status_in = ST_NULL;
            end else if (dup) begin
               status_in = ST_DUP;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               push_ok = 1'b1;
            end
         end
         MODE_POP: begin
            if (badw || busy) begin
               status_in = ST_BADW;
            end else if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               pop_ok = 1'b1;
            end
         end
         MODE_DONE: begin
            if (badw) begin
               status_in = ST_BADW;
            end else begin
               done_ok = 1'b1;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   assign given       = pop_ok ? q_val[0] : '0;
   assign q_ctrl.push = req_fire && push_ok;
   assign q_ctrl.pop  = req_fire && pop_ok;

   always_comb begin
      count_in = count_ff;
      if (q_ctrl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (q_ctrl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_queue
         logic [ID_WIDTH-1:0] nxt;
         if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign nxt = q_val[gi];
         end else begin : g_mid
            assign nxt = q_val[gi+1];
         end
         dwq_queue_cell #(
            .ID_W  (ID_WIDTH),
            .CNT_W (CNT_W),
            .IDX   (gi)
         ) u_cell (
            .clock    (clock),
            .ctrl     (q_ctrl),
            .fill     (count_ff),
            .probe_id (id),
            .next_val (nxt),
            .val      (q_val[gi]),
            .hit      (q_hit[gi])
         );
      end

      for (gi = 0; gi < MAX_WORKERS; gi++) begin : g_slot
         assign s_ctrl[gi].load  = req_fire && pop_ok && ({4'b0000, w} == 7'(gi));
         assign s_ctrl[gi].clear = req_fire && done_ok && ({4'b0000, w} == 7'(gi));
         dwq_slot_cell #(
            .ID_W (ID_WIDTH),
            .IDX  (gi)
         ) u_slot (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (s_ctrl[gi]),
            .active_cnt (active_cnt),
            .load_val   (q_val[0]),
            .probe_id   (id),
            .val        (s_val[gi]),
            .hit        (s_hit[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         wcnt_ff      <= WCNT_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            wcnt_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff <= status_in;
         rsp_item_ff   <= given;
         rsp_occ_ff    <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_occ_ff, rsp_item_ff});

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   a_pop_nonnull: assert property (@(posedge clock) disable iff (reset)
      (req_fire && pop_ok) |-> (q_val[0] != '0))
      else $error("null handle at queue head");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted beat without response");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && push_ok) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not grow the queue");
`endif

endmodule
